// ----- rtl/dvtu_pkg.sv -----
`timescale 1ns / 1ps

package dvtu_pkg;

    localparam int MAX_NODES = 16;
    localparam int DIST_BITS = 16;
    localparam int ID_W      = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * ID_W;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int NCNT_W    = ID_W + 1;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};

    // Input item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LINK  = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Result kinds.
    localparam logic [1:0] RES_CHANGE = 2'd0;
    localparam logic [1:0] RES_FINISH = 2'd1;
    localparam logic [1:0] RES_ROUTE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OWN_ID = 2'd0;
    localparam logic [1:0] REG_NODES  = 2'd1;
    localparam logic [1:0] REG_POISON = 2'd2;

    typedef struct packed {
        logic latch;
        logic clear;
        logic link_wr;
        logic least_upd;
        logic scan_init;
        logic scan_rd;
        logic scan_cmp;
        logic link_rd;
        logic old_rd;
        logic nv_cap;
        logic chg_wr;
        logic emit_route;
        logic emit_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       node_ok;
        logic       entry_ok;
        logic       row_end;
        logic       do_upd;
        logic       row_fin;
        logic       scan_end;
        logic       diff;
        logic       out_free;
    } t_dp_sts;

endpackage

// ----- rtl/dvtu_ram.sv -----
`timescale 1ns / 1ps

module dvtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dvtu_ctrl.sv -----
`timescale 1ns / 1ps

module dvtu_ctrl
    import dvtu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_Q_RD  = 4'd2;
    localparam logic [3:0] S_Q_CMP = 4'd3;
    localparam logic [3:0] S_Q_OUT = 4'd4;
    localparam logic [3:0] S_L_RD  = 4'd5;
    localparam logic [3:0] S_L_RD2 = 4'd6;
    localparam logic [3:0] S_L_CMP = 4'd7;
    localparam logic [3:0] S_L_CHG = 4'd8;
    localparam logic [3:0] S_L_FIN = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_sts.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    KIND_LINK: begin
                        o_cmd.link_wr = i_sts.node_ok;
                    end
                    KIND_QUERY: begin
                        o_cmd.scan_init = 1'b1;
                        n_state = i_sts.node_ok ? S_Q_RD : S_Q_OUT;
                    end
                    default: begin
                        if (i_sts.entry_ok) begin
                            o_cmd.least_upd = 1'b1;
                            if (i_sts.row_end) begin
                                if (i_sts.do_upd) begin
                                    n_state = S_L_RD;
                                end else if (i_sts.row_fin) begin
                                    n_state = S_L_FIN;
                                end
                            end
                        end
                    end
                endcase
            end
            S_Q_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_Q_CMP;
            end
            S_Q_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_sts.scan_end ? S_Q_OUT : S_Q_RD;
            end
            S_Q_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_route = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_L_RD: begin
                o_cmd.link_rd = 1'b1;
                n_state       = S_L_RD2;
            end
            S_L_RD2: begin
                o_cmd.old_rd = 1'b1;
                n_state      = S_L_CMP;
            end
            S_L_CMP: begin
                o_cmd.nv_cap = 1'b1;
                if (i_sts.diff) begin
                    n_state = S_L_CHG;
                end else if (i_sts.row_fin) begin
                    n_state = S_L_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_L_CHG: begin
                if (i_sts.out_free) begin
                    o_cmd.chg_wr = 1'b1;
                    n_state      = i_sts.row_fin ? S_L_FIN : S_IDLE;
                end
            end
            S_L_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/dvtu_datapath.sv -----
`timescale 1ns / 1ps

module dvtu_datapath
    import dvtu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    // Configuration.
    input  logic [ID_W-1:0]      i_own_id,
    input  logic [NCNT_W-1:0]    i_node_count,
    input  logic                 i_poison,
    // Input item.
    input  logic [1:0]           i_kind,
    input  logic [ID_W-1:0]      i_node,
    input  logic [ID_W-1:0]      i_row,
    input  logic [ID_W-1:0]      i_col,
    input  logic [DIST_BITS-1:0] i_value,
    // Result item.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_res_kind,
    output logic [ID_W-1:0]      o_dest,
    output logic [ID_W-1:0]      o_via,
    output logic [DIST_BITS-1:0] o_distance,
    output logic                 o_changed,
    output logic                 o_last
);

    // Latched item.
    logic [1:0]           r_kind;
    logic [ID_W-1:0]      r_node;
    logic [ID_W-1:0]      r_row;
    logic [ID_W-1:0]      r_col;
    logic [DIST_BITS-1:0] r_val;

    logic [DIST_BITS-1:0] r_row_least;
    logic [ID_W-1:0]      r_least_col;
    logic                 r_any_change;
    logic [DEPTH-1:0]     r_vld;
    logic                 r_rd_vld;
    logic [ID_W-1:0]      r_scan_c;
    logic [DIST_BITS-1:0] r_best;
    logic [ID_W-1:0]      r_best_col;
    logic [DIST_BITS-1:0] r_link;
    logic [DIST_BITS-1:0] r_nv;

    logic                 r_out_valid;
    logic [1:0]           r_res_kind;
    logic [ID_W-1:0]      r_dest;
    logic [ID_W-1:0]      r_via;
    logic [DIST_BITS-1:0] r_distance;
    logic                 r_changed;
    logic                 r_last;

    logic [NCNT_W-1:0]    n_eff;
    logic [ID_W-1:0]      n_m1;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DIST_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DIST_BITS-1:0] ram_rdata;
    logic [DIST_BITS-1:0] rd_dist;
    logic [DIST_BITS-1:0] least_base;
    logic [ID_W-1:0]      least_base_col;
    logic                 least_take;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] nv;
    logic                 out_free;

    // Node count limited to the range 1 to MAX_NODES.
    always_comb begin
        if (i_node_count == '0) begin
            n_eff = NCNT_W'(1);
        end else if (i_node_count > NCNT_W'(MAX_NODES)) begin
            n_eff = NCNT_W'(MAX_NODES);
        end else begin
            n_eff = i_node_count;
        end
    end
    assign n_m1 = ID_W'(n_eff - NCNT_W'(1));

    assign out_free = !r_out_valid || i_out_ready;

    // Entry that was never written since the last clear reads as infinite.
    assign rd_dist = r_rd_vld ? ram_rdata : DIST_INF;

    always_comb begin
        least_base     = (r_col == '0) ? DIST_INF : r_row_least;
        least_base_col = (r_col == '0) ? '0 : r_least_col;
        least_take     = !r_val[DIST_BITS-1]
                         && (least_base[DIST_BITS-1] || (r_val < least_base));
    end

    // New entry value: poisoned, infinite through an infinite link, or a saturated sum.
    always_comb begin
        sum = {1'b0, r_link} + {1'b0, r_row_least};
        if (i_poison && (r_least_col == i_own_id)) begin
            nv = DIST_INF;
        end else if (r_link[DIST_BITS-1]) begin
            nv = DIST_INF;
        end else if (sum > {1'b0, DIST_MAX}) begin
            nv = DIST_MAX;
        end else begin
            nv = sum[DIST_BITS-1:0];
        end
    end

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.node_ok  = {1'b0, r_node} < n_eff;
        o_sts.entry_ok = ({1'b0, r_row} < n_eff) && ({1'b0, r_col} < n_eff);
        o_sts.row_end  = (r_col == n_m1);
        o_sts.do_upd   = ({1'b0, r_node} < n_eff) && (r_node != i_own_id)
                         && (r_row != r_node) && (r_row != i_own_id);
        o_sts.row_fin  = (r_row == n_m1);
        o_sts.scan_end = (r_scan_c == n_m1);
        o_sts.diff     = !r_row_least[DIST_BITS-1] && (rd_dist != nv);
        o_sts.out_free = out_free;
    end

    // Memory port selection.
    always_comb begin
        ram_we    = i_cmd.link_wr || i_cmd.chg_wr;
        ram_waddr = i_cmd.chg_wr ? {r_row, r_node} : {r_node, r_node};
        ram_wdata = i_cmd.chg_wr ? r_nv : r_val;
        ram_re    = i_cmd.scan_rd || i_cmd.link_rd || i_cmd.old_rd;
        if (i_cmd.scan_rd) begin
            ram_raddr = {r_node, r_scan_c};
        end else if (i_cmd.old_rd) begin
            ram_raddr = {r_row, r_node};
        end else begin
            ram_raddr = {r_node, r_node};
        end
    end

    dvtu_ram #(
        .WIDTH(DIST_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_node <= i_node;
            r_row  <= i_row;
            r_col  <= i_col;
            r_val  <= i_value[DIST_BITS-1] ? DIST_INF : i_value;
        end
        if (ram_re) begin
            r_rd_vld <= r_vld[ram_raddr];
        end
        if (i_cmd.scan_init) begin
            r_scan_c   <= '0;
            r_best     <= DIST_INF;
            r_best_col <= '0;
        end else if (i_cmd.scan_cmp) begin
            r_scan_c <= r_scan_c + ID_W'(1);
            if (!rd_dist[DIST_BITS-1]
                && (r_best[DIST_BITS-1] || (rd_dist < r_best))) begin
                r_best     <= rd_dist;
                r_best_col <= r_scan_c;
            end
        end
        if (i_cmd.old_rd) begin
            r_link <= rd_dist;
        end
        if (i_cmd.nv_cap) begin
            r_nv <= nv;
        end
        if (i_cmd.emit_route) begin
            r_res_kind <= RES_ROUTE;
            r_dest     <= r_node;
            r_via      <= r_best_col;
            r_distance <= r_best;
            r_changed  <= 1'b0;
            r_last     <= 1'b1;
        end else if (i_cmd.chg_wr) begin
            r_res_kind <= RES_CHANGE;
            r_dest     <= r_row;
            r_via      <= r_node;
            r_distance <= r_nv;
            r_changed  <= 1'b0;
            r_last     <= (r_row != n_m1);
        end else if (i_cmd.emit_fin) begin
            r_res_kind <= RES_FINISH;
            r_dest     <= r_node;
            r_via      <= '0;
            r_distance <= '0;
            r_changed  <= r_any_change;
            r_last     <= 1'b1;
        end
    end

    // Table state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_row_least  <= DIST_INF;
            r_least_col  <= '0;
            r_any_change <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vld        <= '0;
                r_row_least  <= DIST_INF;
                r_least_col  <= '0;
                r_any_change <= 1'b0;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (i_cmd.least_upd) begin
                r_row_least <= least_take ? r_val : least_base;
                r_least_col <= least_take ? r_col : least_base_col;
                if ((r_row == '0) && (r_col == '0)) begin
                    r_any_change <= 1'b0;
                end
            end
            if (i_cmd.chg_wr) begin
                r_any_change <= 1'b1;
            end
            if (i_cmd.emit_fin) begin
                r_any_change <= 1'b0;
            end
            if (i_cmd.emit_route || i_cmd.chg_wr || i_cmd.emit_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res_kind  = r_res_kind;
    assign o_dest      = r_dest;
    assign o_via       = r_via;
    assign o_distance  = r_distance;
    assign o_changed   = r_changed;
    assign o_last      = r_last;

endmodule

// ----- rtl/distance_vector_table_update.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Contents
// s_axis    in         tvalid / tready              kind in tuser, node/row/col/value in tdata
// m_axis    out        tvalid / tready, tlast       result kind in tuser, route, change or finish in tdata
// apb       in         psel, penable, pwrite        own_id, node_count, poison_reverse
//
// Every item passes through the accept and decode states of the controller, and the port is
// ready again only when the controller is back in idle. A clear, a link cost and a streamed
// entry that does not end a row need no more than these. The entry that ends a row may go on
// to read the link cost and the old entry through the single read port of the table memory.
// A route query does one read and one compare per column. A reset or a clear empties the
// table at once through per-entry valid bits, with no clearing pass. A stalled result holds
// the controller until the output register frees.

module distance_vector_table_update
    import dvtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // node[3:0], row[7:4], col[11:8], value[27:12], zeros
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // dest[3:0], via[7:4], distance[23:8], changed[24], zeros
    output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ID_W-1:0]      r_own_id;
    logic [NCNT_W-1:0]    r_node_count;
    logic                 r_poison;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic                 accept_ready;
    logic [ID_W-1:0]      dest;
    logic [ID_W-1:0]      via;
    logic [DIST_BITS-1:0] distance;
    logic                 changed;

    // Register writes complete in the access phase; pready is held high.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= '0;
            r_node_count <= NCNT_W'(MAX_NODES);
            r_poison     <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_OWN_ID: r_own_id     <= pwdata[ID_W-1:0];
                REG_NODES:  r_node_count <= pwdata[NCNT_W-1:0];
                REG_POISON: r_poison     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OWN_ID: prdata = {{(32-ID_W){1'b0}}, r_own_id};
            REG_NODES:  prdata = {{(32-NCNT_W){1'b0}}, r_node_count};
            REG_POISON: prdata = {31'd0, r_poison};
            default:    prdata = '0;
        endcase
    end

    assign s_axis_tready = accept_ready;

    dvtu_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(accept_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    dvtu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_own_id    (r_own_id),
        .i_node_count(r_node_count),
        .i_poison    (r_poison),
        .i_kind      (s_axis_tuser),
        .i_node      (s_axis_tdata[3:0]),
        .i_row       (s_axis_tdata[7:4]),
        .i_col       (s_axis_tdata[11:8]),
        .i_value     (s_axis_tdata[27:12]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res_kind  (m_axis_tuser),
        .o_dest      (dest),
        .o_via       (via),
        .o_distance  (distance),
        .o_changed   (changed),
        .o_last      (m_axis_tlast)
    );

    // The upper input bits carry padding only and are not looked at.
    assign m_axis_tdata = {7'd0, changed, distance, via, dest};

endmodule

// ----- verif/dvtu_checker.sv -----
`timescale 1ns / 1ps

module dvtu_checker
    import dvtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [1:0]           kind;
        logic [ID_W-1:0]      dest;
        logic [ID_W-1:0]      via;
        logic [DIST_BITS-1:0] distance;
        logic                 changed;
        logic                 last;
    } t_route_report;

    logic [DIST_BITS-1:0] dist_tbl [MAX_NODES][MAX_NODES];
    logic [DIST_BITS-1:0] row_least;
    logic [ID_W-1:0]      row_least_col;
    logic                 any_change;
    logic [ID_W-1:0]      own_id;
    logic [NCNT_W-1:0]    node_count;
    logic                 poison;
    t_route_report        reports_due[$];
    int                   fail_count  = 0;
    int                   outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    // Node count is clamped to 1..MAX_NODES.
    function automatic int nodes_in_use();
        if (node_count == 0) return 1;
        if (int'(node_count) > MAX_NODES) return MAX_NODES;
        return int'(node_count);
    endfunction

    function automatic string describe(input t_route_report r);
        return $sformatf("kind %0d dest %0d via %0d distance %0d changed %0b last %0b",
                         r.kind, r.dest, r.via, $signed(r.distance), r.changed, r.last);
    endfunction

    task automatic clear_routes();
        for (int r = 0; r < MAX_NODES; r++) begin
            for (int c = 0; c < MAX_NODES; c++) begin
                dist_tbl[r][c] = DIST_INF;
            end
        end
        row_least     = DIST_INF;
        row_least_col = '0;
        any_change    = 1'b0;
    endtask

    task automatic queue_report(input logic [1:0] kind, input logic [ID_W-1:0] dest,
                                input logic [ID_W-1:0] via,
                                input logic [DIST_BITS-1:0] distance,
                                input logic changed, input logic last);
        t_route_report r;
        r.kind     = kind;
        r.dest     = dest;
        r.via      = via;
        r.distance = distance;
        r.changed  = changed;
        r.last     = last;
        reports_due.insert(reports_due.size(), r);
    endtask

    task automatic answer_query(input logic [ID_W-1:0] target);
        int                   n;
        logic [DIST_BITS-1:0] best;
        logic [DIST_BITS-1:0] d;
        logic [ID_W-1:0]      best_col;
        n        = nodes_in_use();
        best     = DIST_INF;
        best_col = '0;
        if (int'(target) < n) begin
            for (int c = 0; c < n; c++) begin
                d = dist_tbl[target][c];
                if (!d[DIST_BITS-1] && (best[DIST_BITS-1] || d < best)) begin
                    best     = d;
                    best_col = ID_W'(c);
                end
            end
        end
        queue_report(RES_ROUTE, target, best_col, best, 1'b0, 1'b1);
    endtask

    task automatic merge_entry(input logic [ID_W-1:0] nb, input logic [ID_W-1:0] row,
                               input logic [ID_W-1:0] col,
                               input logic [DIST_BITS-1:0] value);
        int                   n;
        logic [DIST_BITS-1:0] link;
        logic [DIST_BITS-1:0] fresh;
        logic [DIST_BITS:0]   total;
        n = nodes_in_use();
        if (int'(row) >= n || int'(col) >= n) return;
        if (row == 0 && col == 0) any_change = 1'b0;
        if (col == 0) begin
            row_least     = DIST_INF;
            row_least_col = '0;
        end
        if (!value[DIST_BITS-1] && (row_least[DIST_BITS-1] || value < row_least)) begin
            row_least     = value;
            row_least_col = col;
        end
        if (int'(col) == n - 1) begin
            if (int'(nb) < n && nb != own_id && row != nb && row != own_id
                && !row_least[DIST_BITS-1]) begin
                link = dist_tbl[nb][nb];
                if (poison && row_least_col == own_id) begin
                    fresh = DIST_INF;
                end else if (link[DIST_BITS-1]) begin
                    fresh = DIST_INF;
                end else begin
                    total = {1'b0, link} + {1'b0, row_least};
                    fresh = (total > {1'b0, DIST_MAX}) ? DIST_MAX : total[DIST_BITS-1:0];
                end
                if (dist_tbl[row][nb] != fresh) begin
                    dist_tbl[row][nb] = fresh;
                    any_change        = 1'b1;
                    queue_report(RES_CHANGE, row, nb, fresh, 1'b0, int'(row) != n - 1);
                end
            end
            if (int'(row) == n - 1) begin
                queue_report(RES_FINISH, nb, '0, '0, any_change, 1'b1);
                any_change = 1'b0;
            end
        end
    endtask

    task automatic take_item();
        logic [1:0]           kind;
        logic [ID_W-1:0]      node;
        logic [DIST_BITS-1:0] raw;
        logic [DIST_BITS-1:0] value;
        kind  = i_s_tuser;
        node  = i_s_tdata[3:0];
        raw   = i_s_tdata[27:12];
        // Every negative distance counts as infinite.
        value = raw[DIST_BITS-1] ? DIST_INF : raw;
        case (kind)
            KIND_CLEAR: clear_routes();
            KIND_LINK: begin
                if (int'(node) < nodes_in_use()) dist_tbl[node][node] = value;
            end
            KIND_ENTRY: merge_entry(node, i_s_tdata[7:4], i_s_tdata[11:8], value);
            KIND_QUERY: answer_query(node);
            default: ;
        endcase
    endtask

    task automatic check_report();
        t_route_report seen;
        t_route_report want;
        seen.kind     = i_m_tuser;
        seen.dest     = i_m_tdata[3:0];
        seen.via      = i_m_tdata[7:4];
        seen.distance = i_m_tdata[23:8];
        seen.changed  = i_m_tdata[24];
        seen.last     = i_m_tlast;
        if (reports_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: %s", describe(seen));
        end else begin
            want = reports_due.pop_front();
            if (seen.kind !== want.kind || seen.dest !== want.dest || seen.via !== want.via
                || seen.distance !== want.distance || seen.changed !== want.changed
                || seen.last !== want.last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected %s, got %s", describe(want), describe(seen));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_routes();
            own_id     = '0;
            node_count = NCNT_W'(16);
            poison     = 1'b0;
            reports_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                case (i_paddr[3:2])
                    REG_OWN_ID: own_id     = i_pwdata[ID_W-1:0];
                    REG_NODES:  node_count = i_pwdata[NCNT_W-1:0];
                    REG_POISON: poison     = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) check_report();
            if (i_s_tvalid && i_s_tready) take_item();
        end
        outstanding = reports_due.size();
    end

endmodule

// ----- verif/tb_distance_vector_table_update.sv -----
`timescale 1ns / 1ps

// Top of the testbench. It drives the input stream, the result back-pressure and the
// configuration port, and gives the verdict. All prediction and comparison is done by the
// checker instantiated beside the block, which hands back its failure count and the number
// of results it is still waiting for.

module tb_distance_vector_table_update;
    import dvtu_pkg::*;

    // The slowest item is a route query over sixteen nodes. The limit allows for roughly 1500
    // such items, each with its result held up by a stalling receiver and preceded by long
    // sender gaps, and then several times that again.
    localparam int CYCLE_LIMIT   = 600000;
    // Quiet time after the last expected result, longer than the slowest query.
    localparam int SETTLE_CYCLES = 80;
    // Length of the deliberate back-pressure stretch.
    localparam int HOLD_CYCLES   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;

    // Idling percentages for the two sides, changed between phases.
    int          sender_idle_pct   = 36;
    int          receiver_idle_pct = 62;

    // The stimulus asks for a back-pressure stretch by raising the request count; the
    // receiver process serves it and counts the stretch itself.
    int          hold_requests = 0;
    int          holds_served  = 0;

    // Configuration as last written, used only to shape the stimulus.
    int          nodes_cur = 16;
    logic [3:0]  own_cur   = '0;

    always #1 i_clk = ~i_clk;

    distance_vector_table_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dvtu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Watchdog: a run that hangs, or that leaves an expected result outstanding for ever,
    // ends here with a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side. Ready changes only at the falling edge. A requested hold keeps ready low
    // for a long stretch so that the block's output register fills and its input stalls.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // One register write: a setup phase, then an access phase that completes at the rising
    // edge where pready is seen high. Called and left at a falling edge.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input logic [3:0] own, input logic [4:0] nodes,
                                input logic poison);
        write_reg(REG_OWN_ID, 32'(own));
        write_reg(REG_NODES, 32'(nodes));
        write_reg(REG_POISON, 32'(poison));
        own_cur   = own;
        nodes_cur = (nodes == 0) ? 1 : ((int'(nodes) > MAX_NODES) ? MAX_NODES : int'(nodes));
    endtask

    // Offers one item, possibly after some idle cycles, and returns at the falling edge after
    // the transaction. Valid stays high when the next item follows straight away.
    task automatic send_item(input logic [1:0] kind, input logic [3:0] node,
                             input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] value);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = {4'b0000, value, col, row, node};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come back, then lets the block finish any work
    // that causes no result (a row-ending entry that finds no change is the longest such case).
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Distances weighted towards the interesting cases: infinite, other negative values,
    // very small costs and values near saturation.
    function automatic logic [15:0] rand_distance();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return 16'hFFFF;
        if (pick < 25) return {1'b1, 15'($urandom)};
        if (pick < 35) return 16'($urandom_range(0, 3));
        if (pick < 42) return 16'(32767 - $urandom_range(0, 3));
        return 16'($urandom_range(0, 1000));
    endfunction

    // Mostly a node in use, now and then any id at all.
    function automatic logic [3:0] rand_node();
        if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, nodes_cur - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // Random traffic for one phase. Most of it is link costs, whole neighbour tables in
    // row-major order and queries; the rest is clears, broken tables and random items.
    task automatic run_random_phase(input int budget);
        int          sent;
        int          pick;
        int          total;
        int          stop_at;
        logic [3:0]  nb;
        logic [15:0] v;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(KIND_LINK, rand_node(), 4'($urandom), 4'($urandom),
                              rand_distance());
                    sent++;
                end
            end else if (pick < 50) begin
                // A neighbour's table; one in ten is cut short somewhere.
                nb      = rand_node();
                total   = nodes_cur * nodes_cur;
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
                for (int i = 0; i < stop_at; i++) begin
                    v = rand_distance();
                    // Make this node the neighbour's best hop now and then, so that poisoned
                    // reverse has something to act on.
                    if (i % nodes_cur == int'(own_cur) && $urandom_range(0, 3) == 0) v = '0;
                    send_item(KIND_ENTRY, nb, 4'(i / nodes_cur), 4'(i % nodes_cur), v);
                    sent++;
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(KIND_QUERY, rand_node(), 4'($urandom), 4'($urandom),
                              16'($urandom));
                    sent++;
                end
            end else if (pick < 82) begin
                send_item(KIND_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
                sent++;
            end else begin
                send_item(2'($urandom_range(1, 3)), 4'($urandom), 4'($urandom), 4'($urandom),
                          16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on a three-node network where this node is node 1.
        apply_config(4'd1, 5'd3, 1'b0);
        // An empty table answers infinite via column 0, as does a query of an unused node.
        send_item(KIND_QUERY, 4'd2, 4'd0, 4'd0, 16'h0000);
        send_item(KIND_QUERY, 4'd15, 4'd15, 4'd15, 16'hFFFF);
        // Link costs: a negative cost other than -1 becomes infinite, then the largest cost;
        // a cost for an unused node is dropped.
        send_item(KIND_LINK, 4'd0, 4'd0, 4'd0, 16'd5);
        send_item(KIND_LINK, 4'd2, 4'd0, 4'd0, 16'h8000);
        send_item(KIND_LINK, 4'd2, 4'd0, 4'd0, 16'h7FFF);
        send_item(KIND_LINK, 4'd9, 4'd0, 4'd0, 16'd3);
        // Neighbour 2 sends its table. Entries outside the used rows and columns are
        // ignored. Row 0 saturates, row 1 is this node's own row and row 2 the neighbour's.
        send_item(KIND_ENTRY, 4'd2, 4'd3, 4'd0, 16'd1);
        send_item(KIND_ENTRY, 4'd2, 4'd0, 4'd0, 16'd4);
        send_item(KIND_ENTRY, 4'd2, 4'd0, 4'd1, 16'hFFFF);
        send_item(KIND_ENTRY, 4'd2, 4'd0, 4'd15, 16'd0);
        send_item(KIND_ENTRY, 4'd2, 4'd0, 4'd2, 16'd2);
        send_item(KIND_ENTRY, 4'd2, 4'd1, 4'd0, 16'd0);
        send_item(KIND_ENTRY, 4'd2, 4'd1, 4'd1, 16'd0);
        send_item(KIND_ENTRY, 4'd2, 4'd1, 4'd2, 16'd0);
        send_item(KIND_ENTRY, 4'd2, 4'd2, 4'd0, 16'd7);
        send_item(KIND_ENTRY, 4'd2, 4'd2, 4'd1, 16'hFFFE);
        send_item(KIND_ENTRY, 4'd2, 4'd2, 4'd2, 16'h7FFF);
        send_item(KIND_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);
        send_item(KIND_LINK, 4'd0, 4'd0, 4'd0, 16'd0);
        send_item(KIND_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);
        // Link cost for this node itself, then a clear empties everything again.
        send_item(KIND_LINK, 4'd1, 4'd15, 4'd15, 16'h7FFF);
        send_item(KIND_CLEAR, 4'd15, 4'd15, 4'd15, 16'hFFFF);
        send_item(KIND_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);

        // Random phases. The first three idle the sender lightly and the receiver heavily,
        // the next two the other way round, and the last two not at all.
        for (int p = 0; p < 7; p++) begin
            settle();
            case (p)
                0: apply_config(4'd0, 5'd4, 1'b0);
                1: apply_config(4'd3, 5'd5, 1'b1);
                2: apply_config(4'd15, 5'd0, 1'b1);
                3: begin
                    sender_idle_pct   = 62;
                    receiver_idle_pct = 36;
                    apply_config(4'd2, 5'd16, 1'b1);
                end
                4: apply_config(4'($urandom_range(0, 2)), 5'd3, 1'b1);
                5: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    apply_config(4'd0, 5'd1, 1'b0);
                end
                default: apply_config(4'd6, 5'd31, 1'b0);
            endcase
            if (p == 3) begin
                // Back-pressure: the receiver holds off while the sender keeps offering
                // queries, which fill the output register and then stall the input.
                hold_requests++;
                repeat (30) send_item(KIND_QUERY, rand_node(), 4'd0, 4'd0, 16'd0);
            end
            case (p)
                2, 5:    run_random_phase(180);
                3:       run_random_phase(200);
                6:       run_random_phase(90);
                default: run_random_phase(240);
            endcase
        end

        settle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
